// ----- sv/fun_pkg.sv -----
// Package with the fixed widths and step counts of the face unit normal pipeline.
`default_nettype none
package fun_pkg;
  localparam int OUT_W = 16;
  localparam int MAG_W = 30;
  localparam int SUM_W = 64;
  localparam int SQ_STEPS = 32;
  localparam int ROOT_W = 31;
  localparam int FRAC_BITS = 14;
  localparam int DIV_STEPS = 15;
  localparam int DIV_W = 46;
  localparam int CHUNK = 8;
  localparam int LANES = 3;
  typedef logic [MAG_W-1:0] mag_t;
  typedef logic [DIV_STEPS-1:0] quo_t;
endpackage
`default_nettype wire

// ----- sv/face_unit_normal.sv -----
// Top level: pipelined unit normal of a triangle face from three vertices.
//
//  channel | ports                              | handshake
//  --------+------------------------------------+---------------------------
//  input   | in_v1_x .. in_v3_z                 | start high, busy low
//  result  | out_normal_x/y/z, out_degenerate   | out_valid strobe, no stall
//
// A transaction enters on every cycle; busy is always low.
// Each result passes through the 32-step square-root pipeline and the
// 15-step divider pipeline.
// Reset clears only the valid bits that travel with the data.
// The receiver cannot stall, so no stage ever holds.
`default_nettype none
module face_unit_normal #(
  parameter int COORD_WIDTH = 16
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic start,
  output logic busy,
  input  wire logic signed [COORD_WIDTH-1:0] in_v1_x,
  input  wire logic signed [COORD_WIDTH-1:0] in_v1_y,
  input  wire logic signed [COORD_WIDTH-1:0] in_v1_z,
  input  wire logic signed [COORD_WIDTH-1:0] in_v2_x,
  input  wire logic signed [COORD_WIDTH-1:0] in_v2_y,
  input  wire logic signed [COORD_WIDTH-1:0] in_v2_z,
  input  wire logic signed [COORD_WIDTH-1:0] in_v3_x,
  input  wire logic signed [COORD_WIDTH-1:0] in_v3_y,
  input  wire logic signed [COORD_WIDTH-1:0] in_v3_z,
  output logic out_valid,
  output logic signed [fun_pkg::OUT_W-1:0] out_normal_x,
  output logic signed [fun_pkg::OUT_W-1:0] out_normal_y,
  output logic signed [fun_pkg::OUT_W-1:0] out_normal_z,
  output logic out_degenerate
);
  import fun_pkg::*;

  localparam int EW = COORD_WIDTH + 1;
  localparam int PW = 2 * EW;
  localparam int CWD = PW + 1;
  localparam int NCH = (CWD + CHUNK - 1) / CHUNK;
  localparam int NW = $clog2(CWD + 1);
  localparam int LAT = 9 + SQ_STEPS + 1 + DIV_STEPS + 1;

  logic [LAT-1:0] vld_r;

  logic signed [EW-1:0] ax_r, ay_r, az_r, bx_r, by_r, bz_r;
  logic signed [PW-1:0] p_r [0:5];
  logic signed [CWD-1:0] c_r [0:LANES-1];
  logic [CWD-1:0] mag_r [0:LANES-1];
  logic [LANES-1:0] neg4_r, neg5_r, neg6_r, neg7_r, neg8_r;
  logic [CWD-1:0] mag5_r [0:LANES-1];
  logic [NCH-1:0] chnz_r;
  logic [2:0] chhi_r [0:NCH-1];
  logic [CWD-1:0] mag6_r [0:LANES-1];
  logic [NW-1:0] n_r;
  logic deg7_r, deg8_r;
  mag_t m7_r [0:LANES-1];
  mag_t m8_r [0:LANES-1];
  logic [2*MAG_W-1:0] sq_r [0:LANES-1];

  logic [SUM_W-1:0] sx_r [0:SQ_STEPS];
  logic [SUM_W-1:0] sr_r [0:SQ_STEPS];
  mag_t sm_r [0:SQ_STEPS][0:LANES-1];
  logic [LANES-1:0] sneg_r [0:SQ_STEPS];
  logic sdeg_r [0:SQ_STEPS];

  logic [DIV_W-1:0] dn_r [0:DIV_STEPS][0:LANES-1];
  quo_t dq_r [0:DIV_STEPS][0:LANES-1];
  logic [ROOT_W-1:0] dl_r [0:DIV_STEPS];
  logic [LANES-1:0] dneg_r [0:DIV_STEPS];
  logic ddeg_r [0:DIV_STEPS];

  logic [NCH*CHUNK-1:0] orw;
  logic [NCH-1:0] chnz_nxt;
  logic [2:0] chhi_nxt [0:NCH-1];
  logic [NW-1:0] n_nxt;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[LAT-2:0], start};
    end
  end

  always_ff @(posedge clk) begin
    ax_r <= EW'(in_v3_x) - EW'(in_v2_x);
    ay_r <= EW'(in_v3_y) - EW'(in_v2_y);
    az_r <= EW'(in_v3_z) - EW'(in_v2_z);
    bx_r <= EW'(in_v2_x) - EW'(in_v1_x);
    by_r <= EW'(in_v2_y) - EW'(in_v1_y);
    bz_r <= EW'(in_v2_z) - EW'(in_v1_z);
    p_r[0] <= PW'(ay_r) * PW'(bz_r);
    p_r[1] <= PW'(az_r) * PW'(by_r);
    p_r[2] <= PW'(az_r) * PW'(bx_r);
    p_r[3] <= PW'(ax_r) * PW'(bz_r);
    p_r[4] <= PW'(ax_r) * PW'(by_r);
    p_r[5] <= PW'(ay_r) * PW'(bx_r);
    for (int i = 0; i < LANES; i++) begin
      c_r[i] <= CWD'(p_r[2*i]) - CWD'(p_r[2*i+1]);
      neg4_r[i] <= c_r[i][CWD-1];
      mag_r[i] <= c_r[i][CWD-1] ? (~c_r[i] + 1'b1) : c_r[i];
      mag5_r[i] <= mag_r[i];
      mag6_r[i] <= mag5_r[i];
      m8_r[i] <= m7_r[i];
      sq_r[i] <= (2*MAG_W)'(m7_r[i]) * (2*MAG_W)'(m7_r[i]);
    end
    neg5_r <= neg4_r;
    neg6_r <= neg5_r;
    neg7_r <= neg6_r;
    neg8_r <= neg7_r;
    chnz_r <= chnz_nxt;
    for (int c = 0; c < NCH; c++) begin
      chhi_r[c] <= chhi_nxt[c];
    end
    n_r <= n_nxt;
    deg7_r <= (n_r == '0);
    deg8_r <= deg7_r;
    for (int i = 0; i < LANES; i++) begin
      m7_r[i] <= MAG_W'({mag6_r[i], {MAG_W{1'b0}}} >> n_r);
    end
    sx_r[0] <= SUM_W'(sq_r[0]) + SUM_W'(sq_r[1]) + SUM_W'(sq_r[2]);
    sr_r[0] <= '0;
    sm_r[0] <= m8_r;
    sneg_r[0] <= neg8_r;
    sdeg_r[0] <= deg8_r;
  end

  always_comb begin
    orw = (NCH*CHUNK)'(mag_r[0] | mag_r[1] | mag_r[2]);
    for (int c = 0; c < NCH; c++) begin
      chnz_nxt[c] = |orw[c*CHUNK +: CHUNK];
      chhi_nxt[c] = '0;
      for (int b = 0; b < CHUNK; b++) begin
        if (orw[c*CHUNK + b]) begin
          chhi_nxt[c] = 3'(b);
        end
      end
    end
  end

  always_comb begin
    n_nxt = '0;
    for (int c = 0; c < NCH; c++) begin
      if (chnz_r[c]) begin
        n_nxt = NW'(c * CHUNK) + NW'(chhi_r[c]) + NW'(1);
      end
    end
  end

  for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sqrt
    localparam logic [SUM_W-1:0] BITV = SUM_W'(1) << (62 - 2*k);
    logic [SUM_W-1:0] t;
    logic ge;
    assign t = sr_r[k] + BITV;
    assign ge = sx_r[k] >= t;
    always_ff @(posedge clk) begin
      sx_r[k+1] <= ge ? (sx_r[k] - t) : sx_r[k];
      sr_r[k+1] <= ge ? ((sr_r[k] >> 1) + BITV) : (sr_r[k] >> 1);
      sm_r[k+1] <= sm_r[k];
      sneg_r[k+1] <= sneg_r[k];
      sdeg_r[k+1] <= sdeg_r[k];
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < LANES; i++) begin
      dn_r[0][i] <= (DIV_W'(sm_r[SQ_STEPS][i]) << FRAC_BITS)
                    + DIV_W'(sr_r[SQ_STEPS][ROOT_W-1:1]);
      dq_r[0][i] <= '0;
    end
    dl_r[0] <= sr_r[SQ_STEPS][ROOT_W-1:0];
    dneg_r[0] <= sneg_r[SQ_STEPS];
    ddeg_r[0] <= sdeg_r[SQ_STEPS];
  end

  for (genvar d = 0; d < DIV_STEPS; d++) begin : g_div
    localparam int J = DIV_STEPS - 1 - d;
    logic [DIV_W-1:0] dv;
    assign dv = DIV_W'(dl_r[d]) << J;
    always_ff @(posedge clk) begin
      for (int i = 0; i < LANES; i++) begin
        if (dn_r[d][i] >= dv) begin
          dn_r[d+1][i] <= dn_r[d][i] - dv;
          dq_r[d+1][i] <= dq_r[d][i] | (quo_t'(1) << J);
        end else begin
          dn_r[d+1][i] <= dn_r[d][i];
          dq_r[d+1][i] <= dq_r[d][i];
        end
      end
      dl_r[d+1] <= dl_r[d];
      dneg_r[d+1] <= dneg_r[d];
      ddeg_r[d+1] <= ddeg_r[d];
    end
  end

  function automatic logic [OUT_W-1:0] signed_q(input quo_t q, input logic neg, input logic deg);
    logic [OUT_W-1:0] v;
    v = OUT_W'(q);
    if (deg) begin
      return '0;
    end
    return neg ? (~v + 1'b1) : v;
  endfunction

  always_ff @(posedge clk) begin
    out_normal_x <= signed_q(dq_r[DIV_STEPS][0], dneg_r[DIV_STEPS][0], ddeg_r[DIV_STEPS]);
    out_normal_y <= signed_q(dq_r[DIV_STEPS][1], dneg_r[DIV_STEPS][1], ddeg_r[DIV_STEPS]);
    out_normal_z <= signed_q(dq_r[DIV_STEPS][2], dneg_r[DIV_STEPS][2], ddeg_r[DIV_STEPS]);
    out_degenerate <= ddeg_r[DIV_STEPS];
  end

  assign out_valid = vld_r[LAT-1];

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    $past(start, LAT) && $past(rst_n, LAT) |-> out_valid)
    else $error("transaction lost in the pipeline");

  a_deg_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_degenerate |->
      (out_normal_x == '0) && (out_normal_y == '0) && (out_normal_z == '0))
    else $error("degenerate face with nonzero normal");

  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_normal_x <= 16384) && (out_normal_x >= -16384)
      && (out_normal_y <= 16384) && (out_normal_y >= -16384)
      && (out_normal_z <= 16384) && (out_normal_z >= -16384))
    else $error("normal component out of range");

endmodule
`default_nettype wire
